// ===== hdl/bcl_pkg.sv =====
// ----------------------------------------------------------------------------
// bcl_pkg
// Shared types and constants for the buffer cache lookup with LRU free list.
// ----------------------------------------------------------------------------
package bcl_pkg;

  localparam int BLK_W = 16;
  localparam int FLG_W = 5;

  // status flag bit positions
  localparam int FL_LOCKED = 0;
  localparam int FL_VALID  = 1;
  localparam int FL_DWR    = 2;
  localparam int FL_OLD    = 3;
  localparam int FL_WAITED = 4;

  typedef enum logic [2:0] {
    OUT_HIT      = 3'd0,
    OUT_MISS     = 3'd1,
    OUT_BUSY     = 3'd2,
    OUT_NONE     = 3'd3,
    OUT_WBACK    = 3'd4,
    OUT_RELEASED = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN
  } state_t;

  // write command to one buffer cell
  typedef struct packed {
    logic             we;
    logic             load_tag;
    logic [FLG_W-1:0] flags;
    logic [BLK_W-1:0] tag;
  } buf_cmd_t;

  // reorder command to the free-list order chain
  typedef struct packed {
    logic mv_front;
    logic mv_back;
  } order_ctl_t;

endpackage

// ===== hdl/bcl_buf_cell.sv =====
// ----------------------------------------------------------------------------
// bcl_buf_cell
// One buffer: its block tag, tag-present bit and status flags, with a tag
// comparator for lookups.
// ----------------------------------------------------------------------------
module bcl_buf_cell import bcl_pkg::*; #(
  parameter int IW = 4,
  parameter int ID = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IW-1:0]    target,
  input  buf_cmd_t         cmd,
  input  logic [BLK_W-1:0] key,
  output logic             match,
  output logic             present,
  output logic [FLG_W-1:0] flags,
  output logic [BLK_W-1:0] tag
);

  logic sel;

  assign sel   = cmd.we && (target == IW'(ID));
  assign match = present && (tag == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b0;
      flags   <= '0;
    end else if (sel) begin
      flags <= cmd.flags;
      if (cmd.load_tag) begin
        present <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.load_tag) begin
      tag <= cmd.tag;
    end
  end

endmodule

// ===== hdl/bcl_order_cell.sv =====
// ----------------------------------------------------------------------------
// bcl_order_cell
// One slot of the LRU order chain. Free buffers in chain order form the
// free list; a buffer moves to the front or back by shifting its neighbors.
// ----------------------------------------------------------------------------
module bcl_order_cell import bcl_pkg::*; #(
  parameter int NB = 16,
  parameter int IW = 4,
  parameter int ID = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  order_ctl_t    ctl,
  input  logic [IW-1:0] b,
  input  logic [IW-1:0] id_left,
  input  logic [IW-1:0] id_right,
  input  logic [NB-1:0] locked,
  input  logic          pre_in,
  input  logic          suf_in,
  input  logic          seen_in,
  output logic          pre_out,
  output logic          suf_out,
  output logic          seen_out,
  output logic          first,
  output logic [IW-1:0] id
);

  logic is_b;
  logic is_free;

  assign is_b     = (id == b);
  assign pre_out  = pre_in | is_b;
  assign suf_out  = suf_in | is_b;
  assign is_free  = !locked[id];
  assign first    = is_free && !seen_in;
  assign seen_out = seen_in | is_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      id <= IW'(ID);
    end else if (ctl.mv_front && suf_out) begin
      id <= id_left;
    end else if (ctl.mv_back && pre_out) begin
      id <= id_right;
    end
  end

endmodule

// ===== hdl/buffer_cache_lookup_lru.sv =====
// ----------------------------------------------------------------------------
// buffer_cache_lookup_lru
// Buffer cache allocator over a fixed pool with an LRU free list.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. In the look state
// that follows, the tags of all buffers are compared at once. A hit or a
// release finishes there. A miss then walks the order chain from its
// free-list head in the scan state, one buffer per cycle, writing back each
// delayed-write buffer it meets. Each result is registered and appears in
// the cycle after it is decided, for one cycle with result_valid high; the
// receiver cannot stall, and last marks the final result of a request.
module buffer_cache_lookup_lru import bcl_pkg::*; #(
  parameter int NUM_BUFFERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [15:0] block_number,
  input  logic [3:0]  buffer_index,
  input  logic        mark_dirty,
  output logic        result_valid,
  output logic [2:0]  outcome,
  output logic [3:0]  result_buffer,
  output logic [15:0] result_block,
  output logic        wake_waiters,
  output logic        not_held,
  output logic        last
);

  localparam int NB = NUM_BUFFERS;
  localparam int IW = $clog2(NB);

  state_t state, state_next;

  logic             req_kind;
  logic [BLK_W-1:0] req_blk;
  logic [3:0]       req_idx;
  logic             req_dirty;

  logic [NB-1:0]    match_v;
  logic [NB-1:0]    present_v;
  logic [NB-1:0]    locked_v;
  logic [FLG_W-1:0] flags_a [NB];
  logic [BLK_W-1:0] tag_a [NB];

  logic [IW-1:0]    ids [NB];
  logic [NB:0]      pre_c;
  logic [NB:0]      suf_c;
  logic [NB:0]      seen_c;
  logic [NB-1:0]    first_v;

  logic [IW-1:0]    target;
  buf_cmd_t         cmd;
  order_ctl_t       octl;
  logic [IW-1:0]    mv_b;

  logic             hit;
  logic [IW-1:0]    hit_idx;
  logic [IW-1:0]    head_id;
  logic             rel_inrange;
  logic [IW-1:0]    rel_b;
  logic [FLG_W-1:0] st;
  logic             dwr;

  logic             emit;
  outcome_t         o_outcome;
  logic [IW-1:0]    o_buf;
  logic [BLK_W-1:0] o_blk;
  logic             o_wake;
  logic             o_nh;
  logic             o_last;

  // buffer cells
  for (genvar i = 0; i < NB; i++) begin : g_buf
    bcl_buf_cell #(.IW(IW), .ID(i)) u_buf (
      .clk     (clk),
      .rst     (rst),
      .target  (target),
      .cmd     (cmd),
      .key     (req_blk),
      .match   (match_v[i]),
      .present (present_v[i]),
      .flags   (flags_a[i]),
      .tag     (tag_a[i])
    );
    assign locked_v[i] = flags_a[i][FL_LOCKED];
  end

  // order chain, head at slot 0
  assign pre_c[0]   = 1'b0;
  assign suf_c[NB]  = 1'b0;
  assign seen_c[0]  = 1'b0;

  for (genvar i = 0; i < NB; i++) begin : g_ord
    logic [IW-1:0] left_id;
    logic [IW-1:0] right_id;
    if (i == 0) begin : g_l
      assign left_id = mv_b;
    end else begin : g_l
      assign left_id = ids[i-1];
    end
    if (i == NB - 1) begin : g_r
      assign right_id = mv_b;
    end else begin : g_r
      assign right_id = ids[i+1];
    end
    bcl_order_cell #(.NB(NB), .IW(IW), .ID(i)) u_ord (
      .clk      (clk),
      .rst      (rst),
      .ctl      (octl),
      .b        (mv_b),
      .id_left  (left_id),
      .id_right (right_id),
      .locked   (locked_v),
      .pre_in   (pre_c[i]),
      .suf_in   (suf_c[i+1]),
      .seen_in  (seen_c[i]),
      .pre_out  (pre_c[i+1]),
      .suf_out  (suf_c[i]),
      .seen_out (seen_c[i+1]),
      .first    (first_v[i]),
      .id       (ids[i])
    );
  end

  // lowest matching buffer
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NB - 1; i >= 0; i--) begin
      if (match_v[i]) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  // first free buffer in chain order (at most one slot is first)
  always_comb begin
    head_id = '0;
    for (int i = 0; i < NB; i++) begin
      head_id = head_id | (first_v[i] ? ids[i] : '0);
    end
  end

  assign rel_inrange = (32'(req_idx) < NB);
  assign rel_b       = IW'(req_idx);
  assign busy        = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_kind  <= kind;
      req_blk   <= block_number;
      req_idx   <= buffer_index;
      req_dirty <= mark_dirty;
    end
  end

  always_comb begin
    state_next = state;
    target     = '0;
    cmd        = '0;
    cmd.tag    = req_blk;
    octl       = '0;
    mv_b       = rel_b;
    st         = flags_a[rel_b];
    dwr        = 1'b0;
    emit       = 1'b0;
    o_outcome  = OUT_HIT;
    o_buf      = '0;
    o_blk      = req_blk;
    o_wake     = 1'b0;
    o_nh       = 1'b0;
    o_last     = 1'b1;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!req_kind) begin
          if (hit) begin
            emit   = 1'b1;
            o_buf  = hit_idx;
            target = hit_idx;
            cmd.we = 1'b1;
            if (flags_a[hit_idx][FL_LOCKED]) begin
              o_outcome = OUT_BUSY;
              cmd.flags = flags_a[hit_idx];
              cmd.flags[FL_WAITED] = 1'b1;
            end else begin
              o_outcome = OUT_HIT;
              cmd.flags[FL_LOCKED] = 1'b1;
              cmd.flags[FL_VALID]  = 1'b1;
              cmd.flags[FL_DWR]    = flags_a[hit_idx][FL_DWR];
            end
            state_next = ST_IDLE;
          end else begin
            state_next = ST_SCAN;
          end
        end else begin
          emit       = 1'b1;
          o_outcome  = OUT_RELEASED;
          o_buf      = rel_b;
          o_blk      = (rel_inrange && present_v[rel_b]) ? tag_a[rel_b] : '0;
          state_next = ST_IDLE;
          if (!rel_inrange || !st[FL_LOCKED]) begin
            o_nh = 1'b1;
          end else begin
            o_wake = st[FL_WAITED];
            if (st[FL_VALID] && !st[FL_OLD]) begin
              octl.mv_back = 1'b1;
            end else begin
              octl.mv_front = 1'b1;
            end
            dwr    = (st[FL_DWR] && !st[FL_OLD]) || req_dirty;
            target = rel_b;
            cmd.we = 1'b1;
            cmd.flags[FL_VALID] = 1'b1;
            cmd.flags[FL_DWR]   = dwr;
          end
        end
      end
      ST_SCAN: begin
        emit = 1'b1;
        if (!seen_c[NB]) begin
          o_outcome  = OUT_NONE;
          state_next = ST_IDLE;
        end else begin
          o_buf  = head_id;
          target = head_id;
          cmd.we = 1'b1;
          cmd.flags[FL_LOCKED] = 1'b1;
          cmd.flags[FL_VALID]  = 1'b1;
          if (flags_a[head_id][FL_DWR]) begin
            // write back and keep walking the free list
            o_outcome = OUT_WBACK;
            o_blk     = tag_a[head_id];
            o_last    = 1'b0;
            cmd.flags[FL_DWR] = 1'b1;
            cmd.flags[FL_OLD] = 1'b1;
          end else begin
            o_outcome    = OUT_MISS;
            cmd.load_tag = 1'b1;
            state_next   = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      outcome       <= o_outcome;
      result_buffer <= 4'(o_buf);
      result_block  <= o_blk;
      wake_waiters  <= o_wake;
      not_held      <= o_nh;
      last          <= o_last;
    end
  end

endmodule

// ===== sim/tb_buffer_cache_lookup_lru.sv =====
// ----------------------------------------------------------------------------
// tb_buffer_cache_lookup_lru
// Self-checking bench: drives get and release requests, predicts every result
// with a behavioral model of the pool and its LRU free list, and compares the
// result stream field by field against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_buffer_cache_lookup_lru import bcl_pkg::*;;

  localparam int NBUF = 16;
  localparam int NIL = NBUF;
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_REL = 1'b1;
  localparam int LIMIT = 200000;

  typedef struct packed {
    outcome_t    oc;
    logic [3:0]  buf_idx;
    logic [15:0] blk;
    logic        wake;
    logic        nh;
    logic        lst;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic kind = 1'b0;
  logic [15:0] block_number = '0;
  logic [3:0] buffer_index = '0;
  logic mark_dirty = 1'b0;
  logic result_valid;
  logic [2:0] outcome;
  logic [3:0] result_buffer;
  logic [15:0] result_block;
  logic wake_waiters;
  logic not_held;
  logic last;

  always #1 clk = ~clk;

  buffer_cache_lookup_lru i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .block_number(block_number), .buffer_index(buffer_index),
    .mark_dirty(mark_dirty), .result_valid(result_valid), .outcome(outcome),
    .result_buffer(result_buffer), .result_block(result_block),
    .wake_waiters(wake_waiters), .not_held(not_held), .last(last)
  );

  // pool model
  logic [15:0]      tags [NBUF];
  logic             has_tag [NBUF];
  logic [FLG_W-1:0] flags [NBUF];
  int               nxt [NBUF];
  int               prv [NBUF];
  int               head, tail;

  res_t pending_results[$];
  int   errors = 0;
  int   cycles = 0;
  bit   idle_on = 1'b1;
  logic [15:0] recent[$];

  task automatic pool_reset();
    for (int i = 0; i < NBUF; i++) begin
      tags[i] = '0;
      has_tag[i] = 1'b0;
      flags[i] = '0;
      nxt[i] = i + 1;
      prv[i] = (i == 0) ? NIL : i - 1;
    end
    head = 0;
    tail = NIL - 1;
  endtask

  task automatic unlink(int b);
    if (prv[b] < NIL) nxt[prv[b]] = nxt[b]; else head = nxt[b];
    if (nxt[b] < NIL) prv[nxt[b]] = prv[b]; else tail = prv[b];
    nxt[b] = NIL;
    prv[b] = NIL;
  endtask

  task automatic push_result(outcome_t oc, int b, logic [15:0] blk,
                             logic wk, logic nh, logic lst);
    res_t r;
    r.oc = oc; r.buf_idx = b[3:0]; r.blk = blk;
    r.wake = wk; r.nh = nh; r.lst = lst;
    pending_results.push_back(r);
  endtask

  task automatic predict_request(logic k, logic [15:0] blk, logic [3:0] bi,
                                 logic md);
    int hit;
    int h;
    int b;
    logic [FLG_W-1:0] st;
    logic [15:0] tg;
    logic dwr;
    hit = NIL;
    if (k == KIND_GET) begin
      for (int i = 0; i < NBUF; i++)
        if (hit == NIL && has_tag[i] && tags[i] == blk) hit = i;
      if (hit < NIL) begin
        if (flags[hit][FL_LOCKED]) begin
          flags[hit][FL_WAITED] = 1'b1;
          push_result(OUT_BUSY, hit, blk, 1'b0, 1'b0, 1'b1);
        end else begin
          st = '0;
          st[FL_LOCKED] = 1'b1; st[FL_VALID] = 1'b1;
          st[FL_DWR] = flags[hit][FL_DWR];
          flags[hit] = st;
          unlink(hit);
          push_result(OUT_HIT, hit, blk, 1'b0, 1'b0, 1'b1);
        end
        return;
      end
      while (head < NIL) begin
        h = head;
        unlink(h);
        if (flags[h][FL_DWR]) begin
          st = '0;
          st[FL_LOCKED] = 1'b1; st[FL_VALID] = 1'b1;
          st[FL_DWR] = 1'b1; st[FL_OLD] = 1'b1;
          flags[h] = st;
          push_result(OUT_WBACK, h, tags[h], 1'b0, 1'b0, 1'b0);
        end else begin
          tags[h] = blk;
          has_tag[h] = 1'b1;
          st = '0;
          st[FL_LOCKED] = 1'b1; st[FL_VALID] = 1'b1;
          flags[h] = st;
          push_result(OUT_MISS, h, blk, 1'b0, 1'b0, 1'b1);
          return;
        end
      end
      push_result(OUT_NONE, 0, blk, 1'b0, 1'b0, 1'b1);
    end else begin
      b = int'(bi);
      tg = has_tag[b] ? tags[b] : '0;
      st = flags[b];
      if (!st[FL_LOCKED]) begin
        push_result(OUT_RELEASED, b, tg, 1'b0, 1'b1, 1'b1);
        return;
      end
      if (st[FL_VALID] && !st[FL_OLD]) begin
        nxt[b] = NIL; prv[b] = tail;
        if (tail < NIL) nxt[tail] = b; else head = b;
        tail = b;
      end else begin
        prv[b] = NIL; nxt[b] = head;
        if (head < NIL) prv[head] = b; else tail = b;
        head = b;
      end
      dwr = st[FL_OLD] ? 1'b0 : st[FL_DWR];
      if (md) dwr = 1'b1;
      flags[b] = '0;
      flags[b][FL_VALID] = 1'b1;
      flags[b][FL_DWR] = dwr;
      push_result(OUT_RELEASED, b, tg, st[FL_WAITED], 1'b0, 1'b1);
    end
  endtask

  // start stays high after the accepting edge until the next request or a pause
  task automatic send_request(logic k, logic [15:0] blk, logic [3:0] bi,
                              logic md);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    block_number <= blk;
    buffer_index <= bi;
    mark_dirty <= md;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(k, blk, bi, md);
    if (k == KIND_GET) begin
      recent.push_back(blk);
      if (recent.size() > 24) void'(recent.pop_front());
    end
  endtask

  // mostly releases of held buffers, now and then of free ones
  function automatic logic [3:0] pick_release();
    int b;
    for (int t = 0; t < 40; t++) begin
      b = $urandom_range(0, NBUF - 1);
      if (has_tag[b] && (flags[b][FL_LOCKED] || t > 30)) return b[3:0];
    end
    for (int i = 0; i < NBUF; i++) if (has_tag[i]) return i[3:0];
    return 4'd0;
  endfunction

  function automatic logic [15:0] pick_block();
    if (recent.size() > 0 && $urandom_range(0, 2) != 0)
      return recent[$urandom_range(0, recent.size() - 1)];
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    res_t want;
    cycles <= cycles + 1;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result outcome=%0d buf=%0d", outcome,
                                  result_buffer);
      end else begin
        want = pending_results.pop_front();
        if (outcome !== want.oc || result_buffer !== want.buf_idx ||
            result_block !== want.blk || wake_waiters !== want.wake ||
            not_held !== want.nh || last !== want.lst) begin
          errors <= errors + 1;
          if (errors < 10)
            $display({"mismatch exp oc=%0d buf=%0d blk=%h wk=%b nh=%b last=%b",
                      " got %0d %0d %h %b %b %b"},
                     want.oc, want.buf_idx, want.blk, want.wake, want.nh, want.lst,
                     outcome, result_buffer, result_block, wake_waiters, not_held,
                     last);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("tb_buffer_cache_lookup_lru: FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(KIND_GET, 16'h0000, 4'd0, 1'b0);  // miss
    send_request(KIND_GET, 16'hFFFF, 4'd0, 1'b0);  // miss
    send_request(KIND_GET, 16'h0000, 4'd0, 1'b0);  // busy wait
    send_request(KIND_REL, 16'h0000, 4'd0, 1'b1);  // wake waiters, set dirty
    send_request(KIND_REL, 16'h0000, 4'd0, 1'b0);  // unheld release
    send_request(KIND_GET, 16'h0000, 4'd0, 1'b0);  // hit keeps dirty mark
    send_request(KIND_REL, 16'h0000, 4'd0, 1'b0);
    send_request(KIND_REL, 16'h0000, 4'd1, 1'b1);
    // exhaust the pool: write-backs then none free
    for (int i = 0; i < 15; i++)
      send_request(KIND_GET, 16'h1000 + 16'(i), 4'd0, 1'b0);
    send_request(KIND_GET, 16'hABCD, 4'hF, 1'b1);
    send_request(KIND_REL, 16'h0000, 4'd0, 1'b0);  // old buffer to head
  endtask

  task automatic test_pause();
    wait_drained();
    send_request(KIND_REL, 16'h0000, pick_release(), 1'b1);
  endtask

  task automatic test_random(int count, bit gaps);
    idle_on = gaps;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 1) == 0)
        send_request(KIND_GET, pick_block(), 4'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)));
      else
        send_request(KIND_REL, 16'($urandom_range(0, 65535)), pick_release(),
                     1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    pool_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pause();
    test_random(240, 1'b1);
    test_random(60, 1'b0);
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("tb_buffer_cache_lookup_lru: PASS");
    else
      $display("tb_buffer_cache_lookup_lru: FAIL");
    $finish;
  end

endmodule
